### hdl/rset_pkg.sv
`default_nettype none

package rset_pkg;

   // Table geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths fixed by the item format
   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int RND_W   = 31;
   localparam int STAT_W  = 2;
   localparam int DIV_CNT_W = $clog2(RND_W);

   typedef logic [CMD_W-1:0]          cmd_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [RND_W-1:0]          rnd_type;
   typedef logic [STAT_W-1:0]         status_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [CNT_W-1:0]          cnt_type;

   // Operation codes
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_RANDOM = 2'd2;

   // Result status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_MISS  = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;       // capture request payload
      logic       match;      // register per-entry match vector
      logic       find;       // encode match vector into slot and hit
      logic       wr_insert;  // append value, count up
      logic       rd_last;    // read last live entry
      logic       wr_move;    // move read data into slot, count down
      logic       div_start;  // clear remainder unit
      logic       div_step;   // one restoring step
      logic       rd_pick;    // read entry at remainder
      logic       resp_load;  // load the result register
      logic       pick_sel;   // result carries read data
      status_type status;
   } rset_ctl_type;

   // Datapath to controller status
   typedef struct packed {
      cmd_type cmd;
      logic    hit;
      logic    full;
      logic    empty;
      logic    div_last;
   } rset_stat_type;

endpackage

`default_nettype wire

### hdl/rset_if.sv
`default_nettype none

// Request channel
interface rset_req_if import rset_pkg::*; ();
   logic      valid;
   logic      ready;
   cmd_type   cmd;
   value_type value;
   rnd_type   random_word;

   modport source (output valid, output cmd, output value, output random_word, input ready);
   modport sink (input valid, input cmd, input value, input random_word, output ready);
endinterface

// Result channel
interface rset_rsp_if import rset_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   value_type  picked;

   modport source (output valid, output status, output picked, input ready);
   modport sink (input valid, input status, input picked, output ready);
endinterface

`default_nettype wire

### hdl/randomized_set_table.sv
// Randomized set table: keeps up to 64 distinct 32-bit values packed in a
// table with a live count. Insert appends an absent value (status 1 on a
// duplicate, 2 when full), remove moves the last entry into the freed slot
// (status 1 when absent), and get random returns the entry at random_word
// modulo the count (status 3 on an empty set); picked is zero unless a get
// random succeeds. One request is worked at a time and each gives one
// result. Insert, remove, undefined codes and get random on an empty set
// pass match, find and execute states (remove also a move state) on to
// the result state; any other get random runs the 31-step bit-serial
// remainder unit and a pick state in between. Membership is a parallel
// match over all live entries. The table needs no clearing pass after
// reset. A result waits in an output register, and a new request is taken
// once the block is back in idle, even while that result is still waiting.
`default_nettype none

module randomized_set_table import rset_pkg::*; (
   input wire       clock,
   input wire       reset,
   rset_req_if.sink   req_ch,
   rset_rsp_if.source rsp_ch
);

   rset_ctl_type  ctl;
   rset_stat_type stat;

   // Sequencer
   rset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Table, match cells and remainder unit
   rset_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_cmd         (req_ch.cmd),
      .req_value       (req_ch.value),
      .req_random_word (req_ch.random_word),
      .rsp_status      (rsp_ch.status),
      .rsp_picked      (rsp_ch.picked)
   );

endmodule

`default_nettype wire

### hdl/rset_dpath.sv
`default_nettype none

module rset_dpath import rset_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  rset_ctl_type  ctl,
   output rset_stat_type stat,
   input  cmd_type       req_cmd,
   input  value_type     req_value,
   input  rnd_type       req_random_word,
   output status_type    rsp_status,
   output value_type     rsp_picked
);

   cmd_type              cmd_ff;
   value_type            value_ff;
   rnd_type              rnd_ff;
   cnt_type              live_count_ff;
   cnt_type              live_count_in;
   value_type            entries_ff [CAPACITY];
   logic [CAPACITY-1:0]  match_ff;
   logic                 hit_ff;
   idx_type              slot_ff;
   idx_type              slot_enc;
   cnt_type              rem_ff;
   cnt_type              rem_in;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       diff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   value_type            rd_ff;
   idx_type              rd_addr;
   cnt_type              count_m1;
   idx_type              wr_addr;
   value_type            wr_data;
   status_type           status_out_ff;
   value_type            picked_out_ff;

   // Request capture and dividend shift register
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         rnd_ff   <= req_random_word;
      end else if (ctl.div_step) begin
         rnd_ff <= {rnd_ff[RND_W-2:0], 1'b0};
      end
   end

   // Live count
   always_comb begin
      live_count_in = live_count_ff;
      if (ctl.wr_insert) begin
         live_count_in = live_count_ff + cnt_type'(1);
      end else if (ctl.wr_move) begin
         live_count_in = live_count_ff - cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_count_ff <= '0;
      end else begin
         live_count_ff <= live_count_in;
      end
   end

   // Single write port into the table, and read address select
   assign count_m1 = live_count_ff - cnt_type'(1);
   assign wr_addr  = ctl.wr_move ? slot_ff : live_count_ff[IDX_W-1:0];
   assign wr_data  = ctl.wr_move ? rd_ff : value_ff;
   assign rd_addr  = ctl.rd_last ? count_m1[IDX_W-1:0] : rem_ff[IDX_W-1:0];

   // Table: match cells, one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_insert || ctl.wr_move) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_last || ctl.rd_pick) begin
         rd_ff <= entries_ff[rd_addr];
      end
      if (ctl.match) begin
         for (int i = 0; i < CAPACITY; i++) begin
            match_ff[i] <= (entries_ff[i] == value_ff) && (cnt_type'(i) < live_count_ff);
         end
      end
   end

   // Match vector to slot index; live values are distinct, so at most one bit
   always_comb begin
      slot_enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_ff[i]) begin
            slot_enc = slot_enc | idx_type'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.find) begin
         slot_ff <= slot_enc;
         hit_ff  <= |match_ff;
      end
   end

   // Restoring remainder: one dividend bit per step
   assign trial = {rem_ff, rnd_ff[RND_W-1]};
   assign diff  = trial - {1'b0, live_count_ff};

   always_comb begin
      if (trial >= {1'b0, live_count_ff}) begin
         rem_in = diff[CNT_W-1:0];
      end else begin
         rem_in = trial[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.div_start) begin
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (ctl.div_step) begin
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (ctl.resp_load) begin
         status_out_ff <= ctl.status;
         picked_out_ff <= ctl.pick_sel ? rd_ff : '0;
      end
   end

   assign rsp_status = status_out_ff;
   assign rsp_picked = picked_out_ff;

   assign stat.cmd      = cmd_ff;
   assign stat.hit      = hit_ff;
   assign stat.full     = (live_count_ff == cnt_type'(CAPACITY));
   assign stat.empty    = (live_count_ff == '0);
   assign stat.div_last = (div_cnt_ff == DIV_CNT_W'(RND_W - 1));

   // Count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= cnt_type'(CAPACITY))
      else $error("live count above capacity");

   // Live values are distinct
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      ctl.find |-> $onehot0(match_ff))
      else $error("more than one live entry matches");

   // An insert grows the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_insert |=> live_count_ff == $past(live_count_ff) + cnt_type'(1))
      else $error("insert did not grow count");

   // Partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> rem_ff < live_count_ff)
      else $error("remainder not below count");

endmodule

`default_nettype wire

### hdl/rset_ctrl.sv
`default_nettype none

module rset_ctrl import rset_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire           rsp_ready,
   input  rset_stat_type stat,
   output rset_ctl_type  ctl
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MATCH = 3'd1;
   localparam logic [2:0] S_FIND  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_MOVE  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_PICK  = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   status_type status_ff;
   status_type status_in;
   logic       pick_ff;
   logic       pick_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.status   = status_ff;
      ctl.pick_sel = pick_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            ctl.match = 1'b1;
            state_in  = S_FIND;
         end
         S_FIND: begin
            ctl.find = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            pick_in  = 1'b0;
            state_in = S_RESP;
            unique case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.hit) begin
                     status_in = ST_MISS;
                  end else if (stat.full) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in     = ST_OK;
                     ctl.wr_insert = 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.hit) begin
                     status_in   = ST_OK;
                     ctl.rd_last = 1'b1;
                     state_in    = S_MOVE;
                  end else begin
                     status_in = ST_MISS;
                  end
               end
               CMD_RANDOM: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     status_in     = ST_OK;
                     pick_in       = 1'b1;
                     ctl.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               default: begin
                  status_in = ST_MISS;
               end
            endcase
         end
         S_MOVE: begin
            ctl.wr_move = 1'b1;
            state_in    = S_RESP;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            ctl.rd_pick = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               ctl.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
         pick_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         pick_ff      <= pick_in;
      end
   end

   // Result register is never overwritten while a transfer is pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.resp_load && rsp_valid_ff) |-> rsp_ready)
      else $error("result overwritten before transfer");

   // Table writes only happen off the idle state
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_insert || ctl.wr_move) |-> !req_ready)
      else $error("table write while idle");

endmodule

`default_nettype wire

### tb/sv/rset_table_checker.sv
// Watches both channels of the set table, keeps its own copy of the set,
// works out the outcome of every request transfer and compares each result
// transfer, field by field, with the oldest outcome still owed.
module rset_table_checker import rset_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rset_req_if         req_mon,
   rset_rsp_if         rsp_mon,
   output int unsigned pending_results,
   output int unsigned fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type status;
      value_type  picked;
   } set_outcome_type;

   // Shadow of the packed table and its live count
   value_type       members [CAPACITY];
   int unsigned     member_count;
   set_outcome_type outcome_queue [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      member_count    = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // Slot of a live member holding val, or -1 when absent
   function automatic int find_member(input value_type val);
      for (int i = 0; i < member_count; i++) begin
         if (members[i] == val) return i;
      end
      return -1;
   endfunction

   // Applies one command to the shadow set and returns what the block owes
   function automatic set_outcome_type run_set_op(input cmd_type op, input value_type val,
                                                  input rnd_type rnd);
      set_outcome_type outcome;
      int              slot;
      outcome.status = ST_OK;
      outcome.picked = '0;
      slot = find_member(val);
      case (op)
         CMD_INSERT: begin
            // duplicate wins over full
            if (slot >= 0) begin
               outcome.status = ST_MISS;
            end else if (member_count >= CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               members[member_count] = val;
               member_count++;
            end
         end
         CMD_REMOVE: begin
            // last live entry fills the hole
            if (slot < 0) begin
               outcome.status = ST_MISS;
            end else begin
               members[slot] = members[member_count - 1];
               member_count--;
            end
         end
         CMD_RANDOM: begin
            if (member_count == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.picked = members[rnd % member_count];
            end
         end
         default: begin
            outcome.status = ST_MISS;
         end
      endcase
      return outcome;
   endfunction

   // Sample both channels at the clock edge
   always @(posedge clock) begin
      set_outcome_type want;
      if (reset) begin
         member_count = 0;
         outcome_queue.delete();
         pending_results <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            outcome_queue = {outcome_queue, run_set_op(req_mon.cmd, req_mon.value,
                                                       req_mon.random_word)};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_queue.size() == 0) begin
               report_mismatch($sformatf("result with nothing owed: status %0d picked %h",
                                         rsp_mon.status, rsp_mon.picked));
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_mon.status, want.status));
               end
               if (rsp_mon.picked !== want.picked) begin
                  report_mismatch($sformatf("picked %h, want %h",
                                            rsp_mon.picked, want.picked));
               end
            end
         end
         pending_results <= outcome_queue.size();
      end
   end

endmodule

### tb/sv/tb_randomized_set_table.sv
module tb_randomized_set_table import rset_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam cmd_type     CMD_RESERVED = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned POOL_SIZE    = 96;
   localparam int unsigned FILL_COUNT   = 80;
   localparam int unsigned TAIL_CYCLES  = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   bit          steady_mode = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned pending_results;
   int unsigned fail_count;
   value_type   value_pool [POOL_SIZE];

   rset_req_if req_bus ();
   rset_rsp_if rsp_bus ();

   randomized_set_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   rset_table_checker u_table_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .pending_results (pending_results),
      .fail_count      (fail_count)
   );

   always #5ns clock = ~clock;

   // Run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random back-pressure, plus a long hold-off on request
   initial begin : result_sink
      int unsigned holds_done;
      holds_done    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= steady_mode || ($urandom_range(99) >= 34);
         end
      end
   end

   function automatic value_type pick_value();
      if ($urandom_range(99) < 80) return value_pool[$urandom_range(POOL_SIZE - 1)];
      return value_type'($urandom);
   endfunction

   // One request transfer, with an occasional gap in front of it
   task automatic send_request(input cmd_type op, input value_type val, input rnd_type rnd);
      if (!steady_mode && $urandom_range(99) < 34) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= op;
      req_bus.value       <= val;
      req_bus.random_word <= rnd;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Random command mix; the remainder after insert and remove is mostly picks
   task automatic send_mixed(input int unsigned ins_pct, input int unsigned rem_pct);
      int unsigned roll;
      cmd_type     op;
      roll = $urandom_range(99);
      if (roll < ins_pct) op = CMD_INSERT;
      else if (roll < ins_pct + rem_pct) op = CMD_REMOVE;
      else if (roll < 97) op = CMD_RANDOM;
      else op = CMD_RESERVED;
      send_request(op, pick_value(), rnd_type'($urandom));
   endtask

   // Stop offering until every owed result has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   initial begin : stimulus
      req_bus.valid       = 1'b0;
      req_bus.cmd         = CMD_INSERT;
      req_bus.value       = '0;
      req_bus.random_word = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // distinct pool: index sits in the low bits
      for (int i = 0; i < POOL_SIZE; i++) begin
         value_pool[i] = value_type'({$urandom(), 7'(i)});
      end

      // Directed: empty set, extremes, duplicates, moves, last entry, bad code
      send_request(CMD_RANDOM, '0, '1);
      send_request(CMD_REMOVE, '0, '0);
      send_request(CMD_RESERVED, '0, '0);
      send_request(CMD_INSERT, 32'sh8000_0000, '0);
      send_request(CMD_INSERT, 32'sh7FFF_FFFF, '0);
      send_request(CMD_INSERT, '0, '0);
      send_request(CMD_INSERT, '1, '0);
      send_request(CMD_INSERT, 32'sh7FFF_FFFF, '1);
      send_request(CMD_RANDOM, '0, '0);
      send_request(CMD_RANDOM, '1, '1);
      send_request(CMD_RANDOM, '0, 31'd5);
      send_request(CMD_REMOVE, 32'sh8000_0000, '0);
      send_request(CMD_RANDOM, '0, '0);
      send_request(CMD_REMOVE, '0, '0);
      send_request(CMD_REMOVE, '0, '0);
      send_request(CMD_REMOVE, 32'sd12345, '0);
      send_request(CMD_RESERVED, 32'sh7FFF_FFFF, '1);
      send_request(CMD_RANDOM, '0, 31'd1);
      send_request(CMD_REMOVE, 32'sh7FFF_FFFF, '0);
      send_request(CMD_REMOVE, '1, '0);
      send_request(CMD_RANDOM, '0, '0);
      send_request(CMD_INSERT, 32'sh5A5A_A5A5, '0);
      wait_for_results();

      // Fill: distinct inserts run the table into full
      for (int i = 0; i < FILL_COUNT; i++) begin
         send_request(CMD_INSERT, value_pool[i], rnd_type'($urandom));
      end
      // Full table: duplicates against full rejects, with picks in between
      repeat (40) send_mixed(60, 0);
      wait_for_results();

      // Drain: remove every pool value and the directed leftover
      for (int i = 0; i < POOL_SIZE; i++) begin
         send_request(CMD_REMOVE, value_pool[i], rnd_type'($urandom));
      end
      send_request(CMD_REMOVE, 32'sh5A5A_A5A5, '0);
      send_request(CMD_RANDOM, '0, rnd_type'($urandom));

      // Churn without any idling
      steady_mode = 1'b1;
      repeat (100) send_mixed(45, 30);
      steady_mode = 1'b0;

      // Churn while the result side holds off for a long stretch
      hold_requests <= hold_requests + 1;
      repeat (100) send_mixed(35, 35);

      // Shrinking mix
      repeat (100) send_mixed(20, 55);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/rset_pkg.sv
hdl/rset_if.sv
hdl/rset_dpath.sv
hdl/rset_ctrl.sv
hdl/randomized_set_table.sv
tb/sv/rset_table_checker.sv
tb/sv/tb_randomized_set_table.sv
